@@ hw/rtl/cau_pkg.sv @@
package cau_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int SUM_BITS  = 2 * WORD_BITS + 1;
   localparam int NUM_BITS  = 2 * WORD_BITS + FRAC_BITS;
   localparam int DEN_BITS  = 2 * WORD_BITS;
   // multiply, sum, prepare, divide setup, one stage per quotient bit, output
   localparam int STAGES    = WORD_BITS + 5;

   typedef enum logic [2:0] {
      KIND_ADD  = 3'd0,
      KIND_SUB  = 3'd1,
      KIND_MUL  = 3'd2,
      KIND_DIV  = 3'd3,
      KIND_CONJ = 3'd4,
      KIND_NEG  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic signed [WORD_BITS-1:0]  a_re;
      logic signed [WORD_BITS-1:0]  a_im;
      logic signed [WORD_BITS-1:0]  b_re;
      logic signed [WORD_BITS-1:0]  b_im;
   } op_type;

   typedef struct packed {
      kind_type                     kind;
      logic                         dz;
      logic signed [WORD_BITS:0]    s_re;
      logic signed [WORD_BITS:0]    s_im;
      logic signed [PROD_BITS-1:0]  p_rr;
      logic signed [PROD_BITS-1:0]  p_ii;
      logic signed [PROD_BITS-1:0]  p_ri;
      logic signed [PROD_BITS-1:0]  p_ir;
      logic signed [PROD_BITS-1:0]  p_bb;
      logic signed [PROD_BITS-1:0]  p_cc;
   } mul_st_type;

   typedef struct packed {
      kind_type                     kind;
      logic                         dz;
      logic signed [WORD_BITS:0]    s_re;
      logic signed [WORD_BITS:0]    s_im;
      logic signed [SUM_BITS-1:0]   m_re;
      logic signed [SUM_BITS-1:0]   m_im;
      logic signed [SUM_BITS-1:0]   n_re;
      logic signed [SUM_BITS-1:0]   n_im;
      logic        [DEN_BITS-1:0]   den;
   } sum_st_type;

   typedef struct packed {
      kind_type                     kind;
      logic                         dz;
      logic signed [SUM_BITS-1:0]   v_re;
      logic signed [SUM_BITS-1:0]   v_im;
      logic                         neg_re;
      logic                         neg_im;
      logic        [NUM_BITS-1:0]   mag_re;
      logic        [NUM_BITS-1:0]   mag_im;
      logic        [DEN_BITS-1:0]   den;
   } prep_st_type;

   typedef struct packed {
      kind_type                     kind;
      logic                         dz;
      logic signed [SUM_BITS-1:0]   v_re;
      logic signed [SUM_BITS-1:0]   v_im;
      logic                         neg_re;
      logic                         neg_im;
      logic                         ov_re;
      logic                         ov_im;
      logic        [DEN_BITS-1:0]   hi_re;
      logic        [DEN_BITS-1:0]   hi_im;
      logic        [WORD_BITS-1:0]  lo_re;
      logic        [WORD_BITS-1:0]  lo_im;
      logic        [DEN_BITS-1:0]   den;
   } div_st_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0]  res_re;
      logic signed [WORD_BITS-1:0]  res_im;
      logic                         overflow;
      logic                         div_zero;
   } res_type;

endpackage

@@ hw/rtl/cau_req_if.sv @@
interface cau_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [2:0]                     kind;
   logic signed [cau_pkg::WORD_BITS-1:0]  a_re;
   logic signed [cau_pkg::WORD_BITS-1:0]  a_im;
   logic signed [cau_pkg::WORD_BITS-1:0]  b_re;
   logic signed [cau_pkg::WORD_BITS-1:0]  b_im;

   modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
   modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

@@ hw/rtl/cau_rsp_if.sv @@
interface cau_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cau_pkg::WORD_BITS-1:0]  res_re;
   logic signed [cau_pkg::WORD_BITS-1:0]  res_im;
   logic                                  overflow;
   logic                                  div_zero;

   modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
   modport sink   (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

@@ hw/rtl/cau_mul.sv @@
module cau_mul (
   input  cau_pkg::op_type      op_i,
   output cau_pkg::mul_st_type  st_o
);

   localparam int XW = cau_pkg::WORD_BITS + 1;

   always_comb begin
      st_o.kind = op_i.kind;
      st_o.dz   = (op_i.kind == cau_pkg::KIND_DIV) && (op_i.b_re == '0) && (op_i.b_im == '0);
      case (op_i.kind)
         cau_pkg::KIND_ADD: begin
            st_o.s_re = XW'(op_i.a_re) + XW'(op_i.b_re);
            st_o.s_im = XW'(op_i.a_im) + XW'(op_i.b_im);
         end
         cau_pkg::KIND_SUB: begin
            st_o.s_re = XW'(op_i.a_re) - XW'(op_i.b_re);
            st_o.s_im = XW'(op_i.a_im) - XW'(op_i.b_im);
         end
         cau_pkg::KIND_CONJ: begin
            st_o.s_re = XW'(op_i.a_re);
            st_o.s_im = -XW'(op_i.a_im);
         end
         cau_pkg::KIND_NEG: begin
            st_o.s_re = -XW'(op_i.a_re);
            st_o.s_im = -XW'(op_i.a_im);
         end
         default: begin
            st_o.s_re = '0;
            st_o.s_im = '0;
         end
      endcase
      st_o.p_rr = op_i.a_re * op_i.b_re;
      st_o.p_ii = op_i.a_im * op_i.b_im;
      st_o.p_ri = op_i.a_re * op_i.b_im;
      st_o.p_ir = op_i.a_im * op_i.b_re;
      st_o.p_bb = op_i.b_re * op_i.b_re;
      st_o.p_cc = op_i.b_im * op_i.b_im;
   end

endmodule

@@ hw/rtl/cau_sum.sv @@
module cau_sum (
   input  cau_pkg::mul_st_type  st_i,
   output cau_pkg::sum_st_type  st_o
);

   localparam int SW = cau_pkg::SUM_BITS;
   localparam int DW = cau_pkg::DEN_BITS;

   always_comb begin
      st_o.kind = st_i.kind;
      st_o.dz   = st_i.dz;
      st_o.s_re = st_i.s_re;
      st_o.s_im = st_i.s_im;
      st_o.m_re = SW'(st_i.p_rr) - SW'(st_i.p_ii);
      st_o.m_im = SW'(st_i.p_ri) + SW'(st_i.p_ir);
      st_o.n_re = SW'(st_i.p_rr) + SW'(st_i.p_ii);
      st_o.n_im = SW'(st_i.p_ir) - SW'(st_i.p_ri);
      // squares are never negative
      st_o.den  = DW'($unsigned(st_i.p_bb)) + DW'($unsigned(st_i.p_cc));
   end

endmodule

@@ hw/rtl/cau_prep.sv @@
module cau_prep (
   input  cau_pkg::sum_st_type   st_i,
   output cau_pkg::prep_st_type  st_o
);

   localparam int SW = cau_pkg::SUM_BITS;
   localparam int NW = cau_pkg::NUM_BITS;

   logic [SW-1:0] mm_re, mm_im, sh_re, sh_im, na_re, na_im;

   always_comb begin
      // product sums shifted down, rounded toward zero
      mm_re = st_i.m_re[SW-1] ? -st_i.m_re : st_i.m_re;
      mm_im = st_i.m_im[SW-1] ? -st_i.m_im : st_i.m_im;
      sh_re = mm_re >> cau_pkg::FRAC_BITS;
      sh_im = mm_im >> cau_pkg::FRAC_BITS;
      na_re = st_i.n_re[SW-1] ? -st_i.n_re : st_i.n_re;
      na_im = st_i.n_im[SW-1] ? -st_i.n_im : st_i.n_im;

      st_o.kind = st_i.kind;
      st_o.dz   = st_i.dz;
      case (st_i.kind)
         cau_pkg::KIND_MUL: begin
            st_o.v_re = st_i.m_re[SW-1] ? -sh_re : sh_re;
            st_o.v_im = st_i.m_im[SW-1] ? -sh_im : sh_im;
         end
         default: begin
            st_o.v_re = SW'(st_i.s_re);
            st_o.v_im = SW'(st_i.s_im);
         end
      endcase
      st_o.neg_re = st_i.n_re[SW-1];
      st_o.neg_im = st_i.n_im[SW-1];
      st_o.mag_re = NW'(na_re) << cau_pkg::FRAC_BITS;
      st_o.mag_im = NW'(na_im) << cau_pkg::FRAC_BITS;
      st_o.den    = st_i.den;
   end

endmodule

@@ hw/rtl/cau_div_init.sv @@
module cau_div_init (
   input  cau_pkg::prep_st_type  st_i,
   output cau_pkg::div_st_type   st_o
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int DW = cau_pkg::DEN_BITS;
   localparam int LW = cau_pkg::DEN_BITS + cau_pkg::WORD_BITS;

   logic [LW-1:0] lim;

   always_comb begin
      // quotient of 2^W or more cannot fit: flag it so the result saturates
      lim         = {st_i.den, {W{1'b0}}};
      st_o.kind   = st_i.kind;
      st_o.dz     = st_i.dz;
      st_o.v_re   = st_i.v_re;
      st_o.v_im   = st_i.v_im;
      st_o.neg_re = st_i.neg_re;
      st_o.neg_im = st_i.neg_im;
      st_o.ov_re  = LW'(st_i.mag_re) >= lim;
      st_o.ov_im  = LW'(st_i.mag_im) >= lim;
      st_o.hi_re  = DW'(st_i.mag_re >> W);
      st_o.hi_im  = DW'(st_i.mag_im >> W);
      st_o.lo_re  = st_i.mag_re[W-1:0];
      st_o.lo_im  = st_i.mag_im[W-1:0];
      st_o.den    = st_i.den;
   end

endmodule

@@ hw/rtl/cau_div_step.sv @@
module cau_div_step (
   input  cau_pkg::div_st_type  st_i,
   output cau_pkg::div_st_type  st_o
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int DW = cau_pkg::DEN_BITS;

   logic [DW:0] t_re, t_im, d_ext, r_re, r_im;
   logic        q_re, q_im;

   always_comb begin
      // restoring step: partial remainder stays below den unless overflow was flagged
      d_ext = {1'b0, st_i.den};
      t_re  = {st_i.hi_re, st_i.lo_re[W-1]};
      t_im  = {st_i.hi_im, st_i.lo_im[W-1]};
      q_re  = t_re >= d_ext;
      q_im  = t_im >= d_ext;
      r_re  = q_re ? t_re - d_ext : t_re;
      r_im  = q_im ? t_im - d_ext : t_im;

      st_o       = st_i;
      st_o.hi_re = r_re[DW-1:0];
      st_o.hi_im = r_im[DW-1:0];
      // low word shifts out dividend bits and fills with quotient bits
      st_o.lo_re = {st_i.lo_re[W-2:0], q_re};
      st_o.lo_im = {st_i.lo_im[W-2:0], q_im};
   end

endmodule

@@ hw/rtl/cau_sat.sv @@
module cau_sat (
   input  cau_pkg::div_st_type  st_i,
   output cau_pkg::res_type     res_o
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int SW = cau_pkg::SUM_BITS;

   localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0] re_v, im_v, re_q, im_q;
   logic         re_vo, im_vo, re_qo, im_qo;

   always_comb begin
      // wide value to word
      re_vo = (st_i.v_re[SW-1:W-1] != '0) && (st_i.v_re[SW-1:W-1] != '1);
      im_vo = (st_i.v_im[SW-1:W-1] != '0) && (st_i.v_im[SW-1:W-1] != '1);
      re_v  = re_vo ? (st_i.v_re[SW-1] ? MIN_NEG : MAX_POS) : st_i.v_re[W-1:0];
      im_v  = im_vo ? (st_i.v_im[SW-1] ? MIN_NEG : MAX_POS) : st_i.v_im[W-1:0];

      // signed quotient from magnitude; negative side reaches one further
      if (st_i.neg_re) begin
         re_qo = st_i.ov_re || (st_i.lo_re > MIN_NEG);
         re_q  = re_qo ? MIN_NEG : -st_i.lo_re;
      end else begin
         re_qo = st_i.ov_re || st_i.lo_re[W-1];
         re_q  = re_qo ? MAX_POS : st_i.lo_re;
      end
      if (st_i.neg_im) begin
         im_qo = st_i.ov_im || (st_i.lo_im > MIN_NEG);
         im_q  = im_qo ? MIN_NEG : -st_i.lo_im;
      end else begin
         im_qo = st_i.ov_im || st_i.lo_im[W-1];
         im_q  = im_qo ? MAX_POS : st_i.lo_im;
      end

      case (st_i.kind)
         cau_pkg::KIND_DIV: begin
            if (st_i.dz) begin
               res_o.res_re   = '0;
               res_o.res_im   = '0;
               res_o.overflow = 1'b0;
               res_o.div_zero = 1'b1;
            end else begin
               res_o.res_re   = re_q;
               res_o.res_im   = im_q;
               res_o.overflow = re_qo || im_qo;
               res_o.div_zero = 1'b0;
            end
         end
         default: begin
            res_o.res_re   = re_v;
            res_o.res_im   = im_v;
            res_o.overflow = re_vo || im_vo;
            res_o.div_zero = 1'b0;
         end
      endcase
   end

endmodule

@@ hw/rtl/complex_arith_unit.sv @@
// Complex ALU on signed Q16.16 operands: add, subtract, multiply, divide, conjugate
// of A and negate A, selected per item by kind. Fully pipelined: one item enters per
// clock unless output back-pressure has filled every stage. The depth is set by
// the divider, which resolves one quotient bit per stage for both parts in
// parallel; every operation runs through the same stages so results stay in order.
// A full stage holds while the stage after it is full and stalled, so bubbles
// close up and the input keeps taking transfers until all stages hold an item.
// Results saturate and flag overflow; divide by 0+0i returns zero with div_zero set.
module complex_arith_unit (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_if,
   cau_rsp_if.source  rsp_if
);

   localparam int W  = cau_pkg::WORD_BITS;
   localparam int NS = cau_pkg::STAGES;

   cau_pkg::op_type       op;
   cau_pkg::mul_st_type   mul_in,  mul_ff;
   cau_pkg::sum_st_type   sum_in,  sum_ff;
   cau_pkg::prep_st_type  prep_in, prep_ff;
   cau_pkg::div_st_type   div_in [0:W];
   cau_pkg::div_st_type   div_ff [0:W];
   cau_pkg::res_type      out_in,  out_ff;

   logic [NS-1:0] vld_ff, vld_in;
   logic [NS:0]   en;

   always_comb begin
      op.kind = cau_pkg::kind_type'(req_if.kind);
      op.a_re = req_if.a_re;
      op.a_im = req_if.a_im;
      op.b_re = req_if.b_re;
      op.b_im = req_if.b_im;
   end

   cau_mul      u_mul  (.op_i(op),      .st_o(mul_in));
   cau_sum      u_sum  (.st_i(mul_ff),  .st_o(sum_in));
   cau_prep     u_prep (.st_i(sum_ff),  .st_o(prep_in));
   cau_div_init u_init (.st_i(prep_ff), .st_o(div_in[0]));

   for (genvar g = 1; g <= W; g++) begin : g_div
      cau_div_step u_step (.st_i(div_ff[g-1]), .st_o(div_in[g]));
   end

   cau_sat u_sat (.st_i(div_ff[W]), .res_o(out_in));

   // a stage loads when it is empty or the next one loads
   always_comb begin
      en[NS] = rsp_if.ready;
      for (int k = NS - 1; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            vld_in[k] = en[k] ? req_if.valid : vld_ff[k];
         end else begin
            vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mul_ff <= mul_in;
      end
      if (en[1]) begin
         sum_ff <= sum_in;
      end
      if (en[2]) begin
         prep_ff <= prep_in;
      end
      if (en[NS-1]) begin
         out_ff <= out_in;
      end
   end

   for (genvar g = 0; g <= W; g++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (en[3+g]) begin
            div_ff[g] <= div_in[g];
         end
      end
   end

   assign req_if.ready    = en[0];
   assign rsp_if.valid    = vld_ff[NS-1];
   assign rsp_if.res_re   = out_ff.res_re;
   assign rsp_if.res_im   = out_ff.res_im;
   assign rsp_if.overflow = out_ff.overflow;
   assign rsp_if.div_zero = out_ff.div_zero;

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock) reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

   a_refuse_full: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (&vld_ff))
      else $error("input refused with a bubble in the pipeline");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.div_zero) |->
         (!rsp_if.overflow && (rsp_if.res_re == '0) && (rsp_if.res_im == '0)))
      else $error("divide by zero result not cleared");
`endif

endmodule
